@@ rtl/lars_pkg.sv @@
package lars_pkg;

   // default geometry of the line ring
   localparam int SLOT_COUNT_DEF  = 8;
   localparam int LINE_LENGTH_DEF = 64;

   // widest slot index and character position over the supported range
   localparam int SLOT_W_MAX = 6;
   localparam int POS_W_MAX  = 8;

   // line end characters
   localparam logic [7:0] CH_LF = 8'h0A;
   localparam logic [7:0] CH_CR = 8'h0D;

   // request kinds
   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_TAKE = 1'b1;

   // take command handed from the front to the back
   typedef struct packed {
      logic                  no_line;
      logic [SLOT_W_MAX-1:0] slot;
   } cmd_type;

   // store update from the front: one character or one closed line length
   typedef struct packed {
      logic                  chr_we;
      logic                  len_we;
      logic [SLOT_W_MAX-1:0] slot;
      logic [POS_W_MAX-1:0]  pos;
      logic [7:0]            data;
   } wr_type;

endpackage

@@ rtl/line_assembling_receive_queue.sv @@
// Line assembling receive queue.
// Request channel: drive req_kind and req_rx_byte with start; the word is taken
// at a clock edge where start is high and busy is low. Kind byte appends the
// character to the line being filled; a newline or carriage return closes it.
// Kind take pops the oldest closed line.
// Result channel: each result word is on the rsp_ ports for one cycle, marked
// by rsp_strobe, and must be taken then; there is no back pressure. A take
// gives its characters one per cycle with rsp_last on the final one, or one
// word with rsp_char_valid low (empty line, or rsp_queue_empty when no line).
// A byte word gives no result. A take with no line waiting is answered from
// its queued word alone; otherwise the back end reads the line length, then
// streams the characters back to back and starts no other take until the
// line is done. Takes wait in a two-word queue; busy rises when it is full,
// or when closing another line would move into the slot still being streamed.
// Reset: synchronous; empties the ring and the queue. Line memory needs no
// clearing, since a slot is read only after it was written.
module line_assembling_receive_queue import lars_pkg::*; #(
   parameter int SLOT_COUNT  = SLOT_COUNT_DEF,
   parameter int LINE_LENGTH = LINE_LENGTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic       req_kind,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_strobe,
   output logic [7:0] rsp_out_char,
   output logic       rsp_char_valid,
   output logic       rsp_queue_empty,
   output logic       rsp_last
);

   localparam int SLOT_W = $clog2(SLOT_COUNT);

   logic              cmd_push;
   cmd_type           push_cmd;
   cmd_type           head_cmd;
   logic              cmd_pop;
   logic              fifo_full;
   logic              fifo_not_empty;
   wr_type            wr;
   logic [SLOT_W-1:0] commit_slot;

   lars_front #(
      .SLOT_COUNT  (SLOT_COUNT),
      .LINE_LENGTH (LINE_LENGTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_kind    (req_kind),
      .req_rx_byte (req_rx_byte),
      .fifo_full   (fifo_full),
      .commit_slot (commit_slot),
      .cmd_push    (cmd_push),
      .cmd         (push_cmd),
      .wr          (wr)
   );

   lars_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_cmd  (push_cmd),
      .pop       (cmd_pop),
      .full      (fifo_full),
      .not_empty (fifo_not_empty),
      .head      (head_cmd)
   );

   lars_back #(
      .SLOT_COUNT  (SLOT_COUNT),
      .LINE_LENGTH (LINE_LENGTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .wr              (wr),
      .cmd_valid       (fifo_not_empty),
      .cmd             (head_cmd),
      .cmd_pop         (cmd_pop),
      .commit_slot     (commit_slot),
      .rsp_strobe      (rsp_strobe),
      .rsp_out_char    (rsp_out_char),
      .rsp_char_valid  (rsp_char_valid),
      .rsp_queue_empty (rsp_queue_empty),
      .rsp_last        (rsp_last)
   );

endmodule

@@ rtl/lars_front.sv @@
module lars_front import lars_pkg::*; #(
   parameter int SLOT_COUNT  = SLOT_COUNT_DEF,
   parameter int LINE_LENGTH = LINE_LENGTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_kind,
   input  logic [7:0]                    req_rx_byte,
   input  logic                          fifo_full,
   input  logic [$clog2(SLOT_COUNT)-1:0] commit_slot,
   output logic                          cmd_push,
   output cmd_type                       cmd,
   output wr_type                        wr
);

   localparam int SLOT_W = $clog2(SLOT_COUNT);
   localparam int POS_W  = $clog2(LINE_LENGTH);

   logic [SLOT_W-1:0] write_slot_ff, write_slot_in;
   logic [SLOT_W-1:0] read_slot_ff, read_slot_in;
   logic [POS_W-1:0]  char_pos_ff, char_pos_in;
   logic [SLOT_W-1:0] write_next;
   logic [SLOT_W-1:0] read_next;
   logic              accept;

   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
      logic [SLOT_W-1:0] n;
      if (s == SLOT_W'(SLOT_COUNT - 1)) begin
         n = '0;
      end else begin
         n = s + SLOT_W'(1);
      end
      return n;
   endfunction

   assign write_next = next_slot(write_slot_ff);
   assign read_next  = next_slot(read_slot_ff);

   // hold input while the queue is full or a line end would reach a slot still streaming
   assign busy   = fifo_full || ((commit_slot != read_slot_ff) && (write_next == commit_slot));
   assign accept = start && !busy;

   // classify the word: append, close the line, or queue a take
   always_comb begin
      write_slot_in = write_slot_ff;
      read_slot_in  = read_slot_ff;
      char_pos_in   = char_pos_ff;
      cmd_push      = 1'b0;
      cmd.no_line   = (read_slot_ff == write_slot_ff);
      cmd.slot      = SLOT_W_MAX'(read_slot_ff);
      wr.chr_we     = 1'b0;
      wr.len_we     = 1'b0;
      wr.slot       = SLOT_W_MAX'(write_slot_ff);
      wr.pos        = POS_W_MAX'(char_pos_ff);
      wr.data       = req_rx_byte;
      if (accept) begin
         case (req_kind)
            KIND_BYTE: begin
               // drop everything while the ring is full
               if (write_next != read_slot_ff) begin
                  if ((req_rx_byte == CH_LF) || (req_rx_byte == CH_CR)) begin
                     wr.len_we     = 1'b1;
                     write_slot_in = write_next;
                     char_pos_in   = '0;
                  end else if (char_pos_ff < POS_W'(LINE_LENGTH - 1)) begin
                     wr.chr_we   = 1'b1;
                     char_pos_in = char_pos_ff + POS_W'(1);
                  end
               end
            end
            KIND_TAKE: begin
               cmd_push = 1'b1;
               if (read_slot_ff != write_slot_ff) begin
                  read_slot_in = read_next;
               end
            end
            default: begin
               cmd_push = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_slot_ff <= '0;
         read_slot_ff  <= '0;
         char_pos_ff   <= '0;
      end else begin
         write_slot_ff <= write_slot_in;
         read_slot_ff  <= read_slot_in;
         char_pos_ff   <= char_pos_in;
      end
   end

endmodule

@@ rtl/lars_cmd_fifo.sv @@
module lars_cmd_fifo import lars_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    full,
   output logic    not_empty,
   output cmd_type head
);

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type           entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];

   // store the pushed word
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   // advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

endmodule

@@ rtl/lars_back.sv @@
module lars_back import lars_pkg::*; #(
   parameter int SLOT_COUNT  = SLOT_COUNT_DEF,
   parameter int LINE_LENGTH = LINE_LENGTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  wr_type                        wr,
   input  logic                          cmd_valid,
   input  cmd_type                       cmd,
   output logic                          cmd_pop,
   output logic [$clog2(SLOT_COUNT)-1:0] commit_slot,
   output logic                          rsp_strobe,
   output logic [7:0]                    rsp_out_char,
   output logic                          rsp_char_valid,
   output logic                          rsp_queue_empty,
   output logic                          rsp_last
);

   localparam int SLOT_W = $clog2(SLOT_COUNT);
   localparam int POS_W  = $clog2(LINE_LENGTH);
   localparam int DEPTH  = SLOT_COUNT * LINE_LENGTH;
   localparam int ADDR_W = $clog2(DEPTH);

   typedef enum logic [1:0] {ST_IDLE, ST_LEN, ST_STRM} state_type;

   logic [7:0]        line_mem [DEPTH];
   logic [POS_W-1:0]  len_mem  [SLOT_COUNT];
   logic [7:0]        line_q_ff;
   logic [POS_W-1:0]  len_q_ff;

   state_type         state_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [POS_W-1:0]  idx_ff;
   logic [SLOT_W-1:0] commit_ff;
   logic              strobe_ff;
   logic [7:0]        char_ff;
   logic              valid_ff;
   logic              empty_ff;
   logic              last_ff;

   logic [SLOT_W-1:0] wr_slot;
   logic [ADDR_W-1:0] wr_addr;
   logic [SLOT_W-1:0] len_addr;
   logic [POS_W-1:0]  rd_pos;
   logic [ADDR_W-1:0] rd_addr;
   logic [POS_W-1:0]  idx_next;
   logic [SLOT_W-1:0] commit_next;

   assign wr_slot  = wr.slot[SLOT_W-1:0];
   assign wr_addr  = ADDR_W'(wr_slot) * ADDR_W'(LINE_LENGTH) + ADDR_W'(wr.pos[POS_W-1:0]);
   assign idx_next = idx_ff + POS_W'(1);
   assign rd_pos   = (state_ff == ST_STRM) ? idx_next : '0;
   assign rd_addr  = ADDR_W'(slot_ff) * ADDR_W'(LINE_LENGTH) + ADDR_W'(rd_pos);
   assign len_addr = (state_ff == ST_IDLE) ? cmd.slot[SLOT_W-1:0] : slot_ff;

   assign commit_next = (commit_ff == SLOT_W'(SLOT_COUNT - 1)) ? '0 : commit_ff + SLOT_W'(1);

   assign cmd_pop     = (state_ff == ST_IDLE) && cmd_valid;
   assign commit_slot = commit_ff;

   // write characters and closed line lengths, read one of each per cycle
   always_ff @(posedge clock) begin
      if (wr.chr_we) begin
         line_mem[wr_addr] <= wr.data;
      end
      line_q_ff <= line_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr.len_we) begin
         len_mem[wr_slot] <= wr.pos[POS_W-1:0];
      end
      len_q_ff <= len_mem[len_addr];
   end

   // run one take: a no-line word, or fetch the length, then stream one character a cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         commit_ff <= '0;
         strobe_ff <= 1'b0;
         slot_ff   <= '0;
         idx_ff    <= '0;
      end else begin
         strobe_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (cmd_valid) begin
                  slot_ff <= cmd.slot[SLOT_W-1:0];
                  if (cmd.no_line) begin
                     strobe_ff <= 1'b1;
                     char_ff   <= '0;
                     valid_ff  <= 1'b0;
                     empty_ff  <= 1'b1;
                     last_ff   <= 1'b1;
                  end else begin
                     state_ff <= ST_LEN;
                  end
               end
            end
            ST_LEN: begin
               if (len_q_ff == '0) begin
                  strobe_ff <= 1'b1;
                  char_ff   <= '0;
                  valid_ff  <= 1'b0;
                  empty_ff  <= 1'b0;
                  last_ff   <= 1'b1;
                  commit_ff <= commit_next;
                  state_ff  <= ST_IDLE;
               end else begin
                  idx_ff   <= '0;
                  state_ff <= ST_STRM;
               end
            end
            ST_STRM: begin
               strobe_ff <= 1'b1;
               char_ff   <= line_q_ff;
               valid_ff  <= 1'b1;
               empty_ff  <= 1'b0;
               last_ff   <= (idx_next == len_q_ff);
               idx_ff    <= idx_next;
               if (idx_next == len_q_ff) begin
                  commit_ff <= commit_next;
                  state_ff  <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_out_char    = char_ff;
   assign rsp_char_valid  = valid_ff;
   assign rsp_queue_empty = empty_ff;
   assign rsp_last        = last_ff;

endmodule

@@ rtl/lars_checker.sv @@
module lars_checker import lars_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       req_kind,
   input logic       rsp_strobe,
   input logic [7:0] rsp_out_char,
   input logic       rsp_char_valid,
   input logic       rsp_queue_empty,
   input logic       rsp_last
);

   // no word follows a reset edge
   a_quiet_after_reset: assert property (@(posedge clock) reset |=> !rsp_strobe)
      else $error("result word right after reset");

   // a no-line answer is a single zero word
   a_empty_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_queue_empty |-> rsp_last && !rsp_char_valid && (rsp_out_char == 8'h00))
      else $error("malformed no-line word");

   // a character word never claims the queue was empty
   a_char_not_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_char_valid |-> !rsp_queue_empty)
      else $error("character word flagged queue empty");

   // a line streams without gaps until its last character
   a_stream_gapless: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |=> rsp_strobe)
      else $error("gap inside a line");

   // answer every take within a bounded time: at most two full lines ahead of it
   a_take_answered: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_kind == KIND_TAKE) |-> ##[2:256] (rsp_strobe && rsp_last))
      else $error("take left unanswered");

endmodule

bind line_assembling_receive_queue lars_checker u_lars_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_kind        (req_kind),
   .rsp_strobe      (rsp_strobe),
   .rsp_out_char    (rsp_out_char),
   .rsp_char_valid  (rsp_char_valid),
   .rsp_queue_empty (rsp_queue_empty),
   .rsp_last        (rsp_last)
);
